/* src/tses_pkg.sv */
// Shared constants, control word type and control program for the timer set scanner.
// No dependencies.
`default_nettype none
package tses_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TIME_W     = 63;
    localparam int ID_W       = 4;
    localparam int MODE_W     = 2;
    localparam int STEP_W     = 2;

    localparam logic [MODE_W-1:0] MODE_ARM    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DISARM = 2'd1;

    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [STEP_W-1:0] STEP_WAIT   = 2'd0;
    localparam logic [STEP_W-1:0] STEP_SCAN   = 2'd1;
    localparam logic [STEP_W-1:0] STEP_REPORT = 2'd2;
    localparam logic [STEP_W-1:0] STEP_SPARE  = 2'd3;

    // what a step waits on before it branches to its target
    typedef enum logic [1:0] {
        HOLD_INPUT = 2'd0,   // until an item is taken
        HOLD_SCAN  = 2'd1,   // until the last slot is done
        HOLD_OUT   = 2'd2,   // until the output register is free
        HOLD_NONE  = 2'd3
    } hold_t;

    typedef struct packed {
        logic              take_in;
        logic              scan;
        logic              report;
        hold_t             hold;
        logic [STEP_W-1:0] target;
    } ctl_t;

    function automatic ctl_t rom_word(input logic [STEP_W-1:0] step);
        ctl_t w;
        w = '{take_in: 1'b0, scan: 1'b0, report: 1'b0, hold: HOLD_NONE, target: STEP_WAIT};
        unique case (step)
            STEP_WAIT: begin
                w.take_in = 1'b1;
                w.hold    = HOLD_INPUT;
                w.target  = STEP_SCAN;
            end
            STEP_SCAN: begin
                w.scan   = 1'b1;
                w.hold   = HOLD_SCAN;
                w.target = STEP_REPORT;
            end
            STEP_REPORT: begin
                w.report = 1'b1;
                w.hold   = HOLD_OUT;
                w.target = STEP_WAIT;
            end
            STEP_SPARE: begin
                w.hold   = HOLD_NONE;
                w.target = STEP_WAIT;
            end
            default: begin
                w.hold   = HOLD_NONE;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* src/timer_set_expiry_scan.sv */
// Timer set with expiry scan: top level, microcoded sequencer and datapath.
// Uses tses_pkg (constants, control word type, control program).
//
// Usage:
// - Input channel s_*: one item carries mode (arm, disarm, check), timer_id,
//   expiry_time and now_time. The arm or disarm is applied in the cycle the
//   item is taken.
// - Result channel m_*: every slot that expired (deadline at or before now)
//   comes out as a kind 0 item in ascending id order and is disarmed; then one
//   kind 1 item with last set gives the time to the earliest remaining
//   deadline, or 0 if nothing is armed.
// - Timing: the wait step takes the item, the scan then walks the deadline
//   array one slot per cycle (16 slots) while no firing slot is held by a
//   full output register, and the report step follows. A new item is taken
//   only after the report step. A fired slot is valid in the cycle after
//   it is scanned.
// - Stalls: a single output register holds a result until taken; the scan
//   holds on a firing slot while that register is full. The next item can be
//   taken while the report still waits in the output register.
// - Reset: all slots disarmed, output empty, sequencer back at its wait step.
`default_nettype none
module timer_set_expiry_scan (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [tses_pkg::MODE_W-1:0] s_mode,
    input  wire logic [tses_pkg::ID_W-1:0]   s_timer_id,
    input  wire logic [tses_pkg::TIME_W-1:0] s_expiry_time,
    input  wire logic [tses_pkg::TIME_W-1:0] s_now_time,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_kind,
    output logic [tses_pkg::ID_W-1:0]        m_fired_id,
    output logic [tses_pkg::TIME_W-1:0]      m_next_interval,
    output logic                             m_last
);
    import tses_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    ctl_t              ctl;

    logic [NUM_TIMERS-1:0] armed_reg;
    logic [TIME_W-1:0]     deadline_reg [NUM_TIMERS];
    logic [IDX_W-1:0]      idx_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     best_reg;
    logic                  any_reg;

    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic [ID_W-1:0]       out_id_reg;
    logic [TIME_W-1:0]     out_interval_reg;
    logic                  out_last_reg;

    logic              take;
    logic              id_ok;
    logic [IDX_W-1:0]  wr_idx;
    logic              out_free;
    logic              slot_armed;
    logic [TIME_W-1:0] slot_dl;
    logic [TIME_W-1:0] slot_diff;
    logic              slot_expired;
    logic              fire;
    logic              slot_done;
    logic              last_slot;
    logic              advance;
    logic              min_upd;

    assign ctl      = rom_word(step_reg);
    assign s_ready  = ctl.take_in;
    assign take     = s_valid && ctl.take_in;
    assign id_ok    = 32'(s_timer_id) < NUM_TIMERS;
    assign wr_idx   = IDX_W'(s_timer_id);
    assign out_free = !out_valid_reg || m_ready;

    assign slot_armed   = armed_reg[idx_reg];
    assign slot_dl      = deadline_reg[idx_reg];
    assign slot_expired = slot_dl <= now_reg;
    assign slot_diff    = slot_dl - now_reg;
    assign fire         = ctl.scan && slot_armed && slot_expired;
    assign slot_done    = ctl.scan && (!fire || out_free);
    assign last_slot    = 32'(idx_reg) == NUM_TIMERS - 1;
    assign min_upd      = ctl.scan && slot_armed && !slot_expired
                          && (!any_reg || slot_diff < best_reg);

    always_comb begin
        unique case (ctl.hold)
            HOLD_INPUT: advance = s_valid;
            HOLD_SCAN:  advance = slot_done && last_slot;
            HOLD_OUT:   advance = out_free;
            HOLD_NONE:  advance = 1'b1;
            default:    advance = 1'b1;
        endcase
        step_next = advance ? ctl.target : step_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_WAIT;
            armed_reg <= '0;
            idx_reg   <= '0;
        end else begin
            step_reg <= step_next;
            if (take) begin
                idx_reg <= '0;
                if (id_ok && s_mode == MODE_ARM) begin
                    armed_reg[wr_idx] <= 1'b1;
                end else if (id_ok && s_mode == MODE_DISARM) begin
                    armed_reg[wr_idx] <= 1'b0;
                end
            end else if (slot_done) begin
                if (fire) begin
                    armed_reg[idx_reg] <= 1'b0;
                end
                if (!last_slot) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    // deadline store and scan working registers
    always_ff @(posedge aclk) begin
        if (take) begin
            now_reg <= s_now_time;
            any_reg <= 1'b0;
            if (id_ok && s_mode == MODE_ARM) begin
                deadline_reg[wr_idx] <= s_expiry_time;
            end
        end else if (min_upd) begin
            best_reg <= slot_diff;
            any_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((fire && out_free) || (ctl.report && out_free)) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && out_free) begin
            out_kind_reg     <= KIND_FIRED;
            out_id_reg       <= ID_W'(idx_reg);
            out_interval_reg <= '0;
            out_last_reg     <= 1'b0;
        end else if (ctl.report && out_free) begin
            out_kind_reg     <= KIND_REPORT;
            out_id_reg       <= '0;
            out_interval_reg <= any_reg ? best_reg : '0;
            out_last_reg     <= 1'b1;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_kind_reg;
    assign m_fired_id      = out_id_reg;
    assign m_next_interval = out_interval_reg;
    assign m_last          = out_last_reg;

endmodule
`default_nettype wire

/* bench/tb_timer_set_expiry_scan.sv */
// Self-checking bench for timer_set_expiry_scan: directed and random arm, disarm and
// check items; fired ids and next-interval reports are compared against a local predictor.
// Depends on tses_pkg and timer_set_expiry_scan.
`timescale 1ns / 1ps

module tb_timer_set_expiry_scan;
    import tses_pkg::*;

    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;   // unused code, acts as a check
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
    localparam int RANDOM_ITEMS   = 450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int QUIET_START    = 3000;
    localparam int QUIET_END      = 6000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] expiry_time;
        logic [TIME_W-1:0] now_time;
    } timer_cmd_t;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   fired_id;
        logic [TIME_W-1:0] next_interval;
        logic              last;
    } timer_event_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [MODE_W-1:0] s_mode = '0;
    logic [ID_W-1:0]   s_timer_id = '0;
    logic [TIME_W-1:0] s_expiry_time = '0;
    logic [TIME_W-1:0] s_now_time = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_kind;
    logic [ID_W-1:0]   m_fired_id;
    logic [TIME_W-1:0] m_next_interval;
    logic              m_last;

    timer_cmd_t   cmd_backlog[$];
    timer_event_t events_due[$];
    timer_cmd_t   cmd_on_bus;

    // predictor copy of the timer set
    logic              slot_armed [NUM_TIMERS];
    logic [TIME_W-1:0] slot_deadline [NUM_TIMERS];

    int cyc = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int items_taken = 0;
    int events_seen = 0;
    int fires_seen = 0;
    int directed_items = 0;

    timer_set_expiry_scan u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_timer_id      (s_timer_id),
        .s_expiry_time   (s_expiry_time),
        .s_now_time      (s_now_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_fired_id      (m_fired_id),
        .m_next_interval (m_next_interval),
        .m_last          (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit take_break();
        return (cyc < QUIET_START || cyc >= QUIET_END) && ($urandom_range(0, 99) < 11);
    endfunction

    task automatic add_cmd(input logic [MODE_W-1:0] mode, input int id,
                           input logic [TIME_W-1:0] expiry, input logic [TIME_W-1:0] now);
        timer_cmd_t c;
        c.mode        = mode;
        c.timer_id    = ID_W'(id);
        c.expiry_time = expiry;
        c.now_time    = now;
        cmd_backlog = {cmd_backlog, c};
    endtask

    // Apply the action, fire everything due in id order, then report time to the next deadline.
    task automatic advance_timer_set(input timer_cmd_t c);
        timer_event_t      ev;
        logic [TIME_W-1:0] nearest;
        logic [TIME_W-1:0] gap;
        bit                found;
        nearest = '0;
        found   = 1'b0;
        if (c.mode == MODE_ARM) begin
            slot_armed[c.timer_id]    = 1'b1;
            slot_deadline[c.timer_id] = c.expiry_time;
        end else if (c.mode == MODE_DISARM) begin
            slot_armed[c.timer_id] = 1'b0;
        end
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (slot_armed[i] && slot_deadline[i] <= c.now_time) begin
                slot_armed[i]    = 1'b0;
                ev.kind          = KIND_FIRED;
                ev.fired_id      = ID_W'(i);
                ev.next_interval = '0;
                ev.last          = 1'b0;
                events_due = {events_due, ev};
            end
        end
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (slot_armed[i]) begin
                gap = slot_deadline[i] - c.now_time;
                if (!found || gap < nearest) begin
                    nearest = gap;
                    found   = 1'b1;
                end
            end
        end
        ev.kind          = KIND_REPORT;
        ev.fired_id      = '0;
        ev.next_interval = nearest;
        ev.last          = 1'b1;
        events_due = {events_due, ev};
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_timer_set(cmd_on_bus);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (cmd_backlog.size() != 0 && !take_break()) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    s_valid       <= 1'b1;
                    s_mode        <= cmd_on_bus.mode;
                    s_timer_id    <= cmd_on_bus.timer_id;
                    s_expiry_time <= cmd_on_bus.expiry_time;
                    s_now_time    <= cmd_on_bus.now_time;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        timer_event_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                events_seen++;
                if (m_kind == KIND_FIRED)
                    fires_seen++;
                if (events_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: kind %0b id %0d interval %0d last %0b",
                                 m_kind, m_fired_id, m_next_interval, m_last);
                end else begin
                    want = events_due.pop_front();
                    if (want.kind !== m_kind || want.fired_id !== m_fired_id ||
                        want.next_interval !== m_next_interval || want.last !== m_last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"result %0d: expected kind %0b id %0d interval %0d",
                                      " last %0b, got kind %0b id %0d interval %0d last %0b"},
                                     events_seen, want.kind, want.fired_id, want.next_interval,
                                     want.last, m_kind, m_fired_id, m_next_interval, m_last);
                    end
                end
            end
            m_ready <= !take_break();
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timer_set_expiry_scan: mismatch");
            $finish;
        end
    end

    initial begin
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] expiry;
        logic [MODE_W-1:0] mode;
        int                r;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            slot_armed[i]    = 1'b0;
            slot_deadline[i] = '0;
        end

        // directed: empty set, far deadline, deadline equal to now, overwrite,
        // disarm of an idle slot, the unused mode, then all sixteen firing at once
        add_cmd(MODE_CHECK, 0, '0, '0);
        add_cmd(MODE_ARM, 0, TIME_MAX, '0);
        add_cmd(MODE_ARM, 15, '0, '0);
        add_cmd(MODE_ARM, 5, 63'd100, 63'd10);
        add_cmd(MODE_ARM, 5, 63'd50, 63'd10);
        add_cmd(MODE_DISARM, 7, TIME_MAX, 63'd10);
        add_cmd(MODE_DISARM, 5, '0, 63'd10);
        add_cmd(MODE_RSVD, 3, 63'd5, 63'd20);
        for (int id = 1; id < NUM_TIMERS; id++)
            add_cmd(MODE_ARM, id, 63'd1000 + 63'(id * 7), 63'd20);
        add_cmd(MODE_CHECK, 9, '0, TIME_MAX);
        directed_items = cmd_backlog.size();

        // random: a drifting clock with deadlines mostly a little ahead of it
        base = 63'd5000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                base = TIME_W'({$urandom, $urandom});
            else
                base = base + 63'($urandom_range(0, 40));
            r = $urandom_range(0, 99);
            if (r < 50)
                mode = MODE_ARM;
            else if (r < 70)
                mode = MODE_DISARM;
            else if (r < 95)
                mode = MODE_CHECK;
            else
                mode = MODE_RSVD;
            r = $urandom_range(0, 99);
            if (r < 80)
                expiry = base + 63'($urandom_range(0, 300));
            else if (r < 90)
                expiry = base - 63'($urandom_range(0, 50));
            else
                expiry = TIME_W'({$urandom, $urandom});
            add_cmd(mode, $urandom_range(0, NUM_TIMERS - 1), expiry, base);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_backlog.size() != 0 || s_valid)
            @(negedge aclk);
        while (events_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("%0d items taken (%0d directed, %0d random), %0d results checked",
                 items_taken, directed_items, items_taken - directed_items, events_seen);
        $display("%0d timers fired, %0d mismatches", fires_seen, errors);
        if (errors == 0 && events_due.size() == 0)
            $display("timer_set_expiry_scan: match");
        else
            $display("timer_set_expiry_scan: mismatch");
        $finish;
    end

endmodule

/* files.f */
src/tses_pkg.sv
src/timer_set_expiry_scan.sv
bench/tb_timer_set_expiry_scan.sv
